// File: hdl/lzss_pkg.sv
// Package for the LZSS window decoder: window geometry, config register
// indexes and the sequencer state type. No dependencies.
`default_nettype none

package lzss_pkg;

  localparam int unsigned WIN_DEPTH = 2048;
  localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);
  localparam int unsigned LEN_W     = 6;     // copy length 3..34

  localparam logic [LEN_W-1:0] LEN_BIAS         = LEN_W'(3);
  localparam logic [3:0]       ENTRIES_PER_FLAG = 4'd8;

  // config register indexes
  localparam logic CFG_UNPACKED_SIZE = 1'b0;
  localparam logic CFG_WINDOW_START  = 1'b1;

  typedef enum logic [1:0] {
    S_CLR,   // zeroing the window after reset
    S_IDLE,  // waiting for a compressed byte
    S_RD,    // window read for one copied byte
    S_WR     // emit and store the copied byte
  } state_t;

endpackage

`default_nettype wire

// File: hdl/lzss_window_decoder.sv
// LZSS decoder, 2 KiB window. A literal shows on out_* the cycle after acceptance;
// a flag byte or first reference byte gives no item.
// A reference copies its 3..34 bytes one at a time, each by a window read, then a write/emit
// that waits while the output is stalled; input is held off until the copy ends.
// Reset (rst_n, synchronous): a clear pass then zeroes the window, in_tready stays low.
// Config writes are taken in every state, the clear pass too; window start only while bytes_out is 0.
//
// Depends on lzss_pkg.
`default_nettype none

module lzss_window_decoder
  import lzss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // compressed stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  // decompressed stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] out_byte
  output logic             out_tlast,  // last_of_run
  output logic             out_tuser,  // [0] stream_done
  // config write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [WIN_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [31:0]       size_r, size_nxt;
  logic [31:0]       bytes_out_r, bytes_out_nxt;
  logic [WIN_AW-1:0] write_pos_r, write_pos_nxt;
  logic [7:0]        flag_r, flag_nxt;
  logic [3:0]        entries_r, entries_nxt;
  logic              ref_phase_r, ref_phase_nxt;
  logic [7:0]        ref_low_r, ref_low_nxt;
  logic [WIN_AW-1:0] src_r, src_nxt;
  logic [WIN_AW-1:0] dst_r, dst_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [7:0]        rd_data_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_done_r, out_done_nxt;

  // window memory
  logic [7:0]        win_mem [WIN_DEPTH];
  logic              mem_we;
  logic [WIN_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  logic              stream_done;
  logic [32:0]       bytes_inc;
  logic              inc_done;
  logic              out_free;
  logic              in_acc;
  logic [LEN_W-1:0]  ref_len;

  assign stream_done = bytes_out_r >= size_r;
  assign bytes_inc   = {1'b0, bytes_out_r} + 33'd1;
  assign inc_done    = bytes_inc >= {1'b0, size_r};
  assign out_free    = !out_valid_r || out_tready;
  assign in_tready   = (state_r == S_IDLE) && out_free;
  assign in_acc      = in_tvalid && in_tready;
  assign ref_len     = LEN_W'(in_tdata[4:0]) + LEN_BIAS;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    size_nxt       = size_r;
    bytes_out_nxt  = bytes_out_r;
    write_pos_nxt  = write_pos_r;
    flag_nxt       = flag_r;
    entries_nxt    = entries_r;
    ref_phase_nxt  = ref_phase_r;
    ref_low_nxt    = ref_low_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    mem_we         = 1'b0;
    mem_waddr      = write_pos_r;
    mem_wdata      = in_tdata;

    unique case (state_r)
      S_CLR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = 8'h00;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == WIN_AW'(WIN_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // finished stream: item is consumed and dropped
        if (in_acc && !stream_done) begin
          if (entries_r == 4'd0) begin
            flag_nxt    = in_tdata;
            entries_nxt = ENTRIES_PER_FLAG;
          end else if (flag_r[0]) begin
            // literal: store, emit, advance
            mem_we        = 1'b1;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = in_tdata;
            out_last_nxt  = 1'b1;
            out_done_nxt  = inc_done;
            bytes_out_nxt = bytes_inc[31:0];
            write_pos_nxt = write_pos_r + 1'b1;
            flag_nxt      = flag_r >> 1;
            entries_nxt   = entries_r - 1'b1;
          end else if (!ref_phase_r) begin
            ref_low_nxt   = in_tdata;
            ref_phase_nxt = 1'b1;
          end else begin
            // second reference byte: set up the copy; write_pos jumps to
            // its end even if the copy is cut short by unpacked_size
            src_nxt       = {in_tdata[7:5], ref_low_r};
            dst_nxt       = write_pos_r;
            rem_nxt       = ref_len;
            write_pos_nxt = write_pos_r + WIN_AW'(ref_len);
            ref_phase_nxt = 1'b0;
            flag_nxt      = flag_r >> 1;
            entries_nxt   = entries_r - 1'b1;
            state_nxt     = S_RD;
          end
        end
      end

      S_RD: begin
        state_nxt = S_WR;
      end

      S_WR: begin
        // byte-at-a-time copy: an overlapping source sees the bytes
        // written by earlier steps, since each read follows the last write
        if (out_free) begin
          mem_we        = 1'b1;
          mem_waddr     = dst_r;
          mem_wdata     = rd_data_r;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_last_nxt  = (rem_r == LEN_W'(1)) || inc_done;
          out_done_nxt  = inc_done;
          bytes_out_nxt = bytes_inc[31:0];
          src_nxt       = src_r + 1'b1;
          dst_nxt       = dst_r + 1'b1;
          rem_nxt       = rem_r - 1'b1;
          if ((rem_r == LEN_W'(1)) || inc_done) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      default: state_nxt = S_CLR;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNPACKED_SIZE: size_nxt = cfg_wdata;
        CFG_WINDOW_START: begin
          if (bytes_out_r == 32'd0) begin
            write_pos_nxt = cfg_wdata[WIN_AW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      size_r      <= '0;
      bytes_out_r <= '0;
      write_pos_r <= '0;
      flag_r      <= '0;
      entries_r   <= '0;
      ref_phase_r <= 1'b0;
      ref_low_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      size_r      <= size_nxt;
      bytes_out_r <= bytes_out_nxt;
      write_pos_r <= write_pos_nxt;
      flag_r      <= flag_nxt;
      entries_r   <= entries_nxt;
      ref_phase_r <= ref_phase_nxt;
      ref_low_r   <= ref_low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    rem_r      <= rem_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  // window: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_RD) begin
      rd_data_r <= win_mem[src_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

`ifndef ASSERT_OFF
  a_no_input_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !in_tready)
    else $error("input accepted during window clear");

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_WR))
    else $error("window read not followed by write step");

  a_copy_len_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RD) || (state_r == S_WR)) |-> (rem_r != '0))
    else $error("copy running with zero bytes left");

  a_copy_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WR) && (state_nxt == S_IDLE)) |=> (out_tvalid && out_tlast))
    else $error("copy ended without last_of_run on its final item");
`endif

endmodule

`default_nettype wire
